// File: hw/rtl/striped_bitmap_block_allocator_assert.svh
// Assertion macros used by the block allocator datapath
`ifndef STRIPED_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define STRIPED_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Check a condition in the same cycle as its trigger (needs clk and rst_n in scope)
`define SBBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define SBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbba_pkg.sv
// Shared constants, codes and controller/datapath interface types of the block allocator
`timescale 1ns / 1ps
`default_nettype none

package sbba_pkg;

  // Default map size in bits
  localparam int unsigned MAP_BITS_DEF = 1024;

  // Map word geometry (one map word is one stripe word)
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned OFS_W   = 6;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned WSEL_W  = POS_W - OFS_W;
  localparam int unsigned POS_MAX = (1 << POS_W) - 1;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SIDX_W = 10;
  localparam int unsigned WIDX_W = 4;
  localparam int unsigned SLEN_W = 11;
  localparam int unsigned SC_W   = 11;
  localparam int unsigned BIDX_W = WIDX_W + OFS_W;
  localparam int unsigned R_W    = BIDX_W + SC_W + 1;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned BLK_W  = 64;
  localparam int unsigned STAT_W = 2;

  // Stream and configuration port widths
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned CFG_AW     = 2;
  localparam int unsigned CFG_DW     = 64;

  // Register reset values
  localparam int unsigned REGION_RST  = 1024;
  localparam int unsigned STRIPES_RST = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_DROPPED  = 2'd2
  } stat_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_BASE    = 2'd0,
    CFG_REGION  = 2'd1,
    CFG_STRIPES = 2'd2
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic ld_calc;
    logic ld_rd;
    logic ld_oor;
    logic ld_wr;
    logic ld_next;
    logic al_start;
    logic al_scan;
    logic al_step;
    logic al_hit;
    logic al_miss;
    logic push;
  } sbba_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic bit_ok;
    logic bit_last;
    logic r_ok;
    logic al_empty;
    logic al_found;
    logic al_last;
    logic out_free;
  } sbba_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sbba_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sbba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbba_ctrl.sv
// Command sequencer of the block allocator: clear sweep, load bit walk, allocate scan
`timescale 1ns / 1ps
`default_nettype none

module sbba_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic [sbba_pkg::CMD_W-1:0]   in_tuser,
  output logic                         in_tready,
  input  sbba_pkg::sbba_sts_t          sts_i,
  output sbba_pkg::sbba_ctl_t          ctl_o
);

  import sbba_pkg::*;

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_CLEAR   = 8'b0000_0100,
    S_LD_BIT  = 8'b0000_1000,
    S_LD_CHK  = 8'b0001_0000,
    S_LD_WR   = 8'b0010_0000,
    S_AL_SCAN = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ctl_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl_o.latch = 1'b1;
          unique case (cmd_t'(in_tuser))
            CMD_CLEAR: begin
              ctl_o.clr_start = 1'b1;
              state_nxt       = S_CLEAR;
            end
            CMD_LOAD: begin
              state_nxt = S_LD_BIT;
            end
            CMD_ALLOC: begin
              if (sts_i.al_empty) begin
                ctl_o.al_miss = 1'b1;
                state_nxt     = S_DONE;
              end else begin
                ctl_o.al_start = 1'b1;
                state_nxt      = S_AL_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_LD_BIT: begin
        if (sts_i.bit_ok) begin
          ctl_o.ld_calc = 1'b1;
          state_nxt     = S_LD_CHK;
        end else if (sts_i.bit_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl_o.ld_next = 1'b1;
        end
      end
      S_LD_CHK: begin
        ctl_o.ld_rd = 1'b1;
        if (sts_i.r_ok) begin
          state_nxt = S_LD_WR;
        end else begin
          ctl_o.ld_oor = 1'b1;
          if (sts_i.bit_last) begin
            state_nxt = S_DONE;
          end else begin
            ctl_o.ld_next = 1'b1;
            state_nxt     = S_LD_BIT;
          end
        end
      end
      S_LD_WR: begin
        ctl_o.ld_wr = 1'b1;
        if (sts_i.bit_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl_o.ld_next = 1'b1;
          state_nxt     = S_LD_BIT;
        end
      end
      S_AL_SCAN: begin
        ctl_o.al_scan = 1'b1;
        if (sts_i.al_found) begin
          ctl_o.al_hit = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts_i.al_last) begin
          ctl_o.al_miss = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          ctl_o.al_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.push = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State register; reset starts the map clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbba_dp.sv
// Datapath of the block allocator: registers, free map memory, scan logic, output stage
`timescale 1ns / 1ps
`default_nettype none
`include "striped_bitmap_block_allocator_assert.svh"

module sbba_dp #(
  parameter int unsigned MAP_BITS = sbba_pkg::MAP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbba_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [sbba_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic [sbba_pkg::IN_DATA_W-1:0]    in_tdata,
  input  sbba_pkg::sbba_ctl_t               ctl_i,
  output sbba_pkg::sbba_sts_t               sts_o,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbba_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [sbba_pkg::STAT_W-1:0]       out_tuser
);

  import sbba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned MAP_CAP   = (MAP_BITS < POS_MAX) ? MAP_BITS : POS_MAX;
  localparam int unsigned HINT_RST  = (REGION_RST < MAP_CAP) ? REGION_RST : MAP_CAP;

  // Input word layout
  localparam int unsigned SIDX_LSB = 0;
  localparam int unsigned WIDX_LSB = SIDX_LSB + SIDX_W;
  localparam int unsigned WORD_LSB = WIDX_LSB + WIDX_W;
  localparam int unsigned SLEN_LSB = WORD_LSB + WORD_W;

  // Configuration registers
  logic [BLK_W-1:0]  base_r;
  logic [POS_W-1:0]  region_r;
  logic [SC_W-1:0]   sc_r;

  // Latched input word
  logic [SIDX_W-1:0] sidx_r;
  logic [WIDX_W-1:0] widx_r;
  logic [WORD_W-1:0] word_r;
  logic [SLEN_W-1:0] slen_r;

  // Working state
  logic [OFS_W-1:0]  bit_r;
  logic [R_W-1:0]    r_r;
  logic [POS_W-1:0]  hint_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AW-1:0]     clr_r;
  logic [WSEL_W-1:0] w_r;
  logic              first_r;
  logic              res_hit_r;
  logic [POS_W-1:0]  res_pos_r;
  stat_t             res_stat_r;

  // Output stage
  logic              out_valid_r;
  logic [BLK_W-1:0]  out_blk_r;
  stat_t             out_stat_r;
  logic [CNT_W-1:0]  out_cnt_r;

  // Memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Combinational values
  logic [POS_W-1:0]  size;
  logic [POS_W-1:0]  size_m1;
  logic [BIDX_W-1:0] b;
  logic [R_W-1:0]    r_calc;
  logic [POS_W-1:0]  r_pos;
  logic [AW-1:0]     r_word;
  logic [WORD_W-1:0] r_mask;
  logic              r_ok;
  logic [WSEL_W-1:0] w_inc;
  logic              al_last;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] cand;
  logic [OFS_W-1:0]  hit_ofs;
  logic [POS_W-1:0]  hit_pos;
  logic              out_free;
  logic [2:0]        map_wr_src;

  // Lowest set bit of a map word
  function automatic logic [OFS_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [OFS_W-1:0] idx;
    idx = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = OFS_W'(k);
      end
    end
    return idx;
  endfunction

  sbba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Region size clamped to the map
  assign size    = (region_r < POS_W'(MAP_CAP)) ? region_r : POS_W'(MAP_CAP);
  assign size_m1 = size - 1'b1;

  // Load: stripe bit index and its region position
  assign b      = {widx_r, bit_r};
  assign r_calc = R_W'(sidx_r) + R_W'(b) * R_W'(sc_r);
  assign r_ok   = r_r < R_W'(size);
  assign r_pos  = r_r[POS_W-1:0];
  assign r_word = AW'(r_pos[POS_W-1:OFS_W]);
  assign r_mask = WORD_W'(1) << r_pos[OFS_W-1:0];

  // Allocate: keep bits from the hint up to the last region bit
  assign w_inc   = w_r + 1'b1;
  assign al_last = (w_r == size_m1[POS_W-1:OFS_W]);
  assign lo_mask = first_r ? ({WORD_W{1'b1}} << hint_r[OFS_W-1:0]) : {WORD_W{1'b1}};
  assign hi_mask = al_last ? ({WORD_W{1'b1}} >> (OFS_W'(WORD_W - 1) - size_m1[OFS_W-1:0]))
                           : {WORD_W{1'b1}};
  assign cand    = ram_rdata & lo_mask & hi_mask;
  assign hit_ofs = lowest_one(cand);
  assign hit_pos = {w_r, hit_ofs};

  assign out_free = !out_valid_r || out_tready;

  // Map write sources, at most one per cycle
  assign map_wr_src = {ctl_i.clr_step, ctl_i.ld_wr, ctl_i.al_hit};

  // Status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = (clr_r == AW'(MAP_WORDS - 1));
    sts_o.bit_ok   = word_r[bit_r] && ({1'b0, b} < slen_r);
    sts_o.bit_last = (bit_r == '1);
    sts_o.r_ok     = r_ok;
    sts_o.al_empty = (hint_r >= size);
    sts_o.al_found = |cand;
    sts_o.al_last  = al_last;
    sts_o.out_free = out_free;
  end

  // Memory write: clear sweep, bit set on load, bit clear on allocate
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (ctl_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (ctl_i.ld_wr) begin
      ram_we    = 1'b1;
      ram_waddr = r_word;
      ram_wdata = ram_rdata | r_mask;
    end else if (ctl_i.al_hit) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(w_r);
      ram_wdata = ram_rdata & ~(WORD_W'(1) << hit_ofs);
    end
  end

  // Memory read: load target, next scan word, or the hint word while idle
  always_comb begin
    if (ctl_i.ld_rd) begin
      ram_raddr = r_word;
    end else if (ctl_i.al_scan) begin
      ram_raddr = AW'(w_inc);
    end else begin
      ram_raddr = AW'(hint_r[POS_W-1:OFS_W]);
    end
  end

  // Control state: configuration, hint, count, sweep counter, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      region_r    <= POS_W'(REGION_RST);
      sc_r        <= SC_W'(STRIPES_RST);
      hint_r      <= POS_W'(HINT_RST);
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_BASE:    base_r   <= cfg_wdata;
          CFG_REGION:  region_r <= cfg_wdata[POS_W-1:0];
          CFG_STRIPES: sc_r     <= cfg_wdata[SC_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.clr_start) begin
        hint_r <= size;
        cnt_r  <= '0;
        clr_r  <= '0;
      end
      if (ctl_i.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl_i.ld_wr) begin
        if (r_pos < hint_r) begin
          hint_r <= r_pos;
        end
        if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (ctl_i.al_hit) begin
        hint_r <= hit_pos + 1'b1;
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      if (ctl_i.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: latched word, bit walk, scan position, result, output word
  always_ff @(posedge clk) begin
    if (ctl_i.latch) begin
      sidx_r     <= in_tdata[SIDX_LSB +: SIDX_W];
      widx_r     <= in_tdata[WIDX_LSB +: WIDX_W];
      word_r     <= in_tdata[WORD_LSB +: WORD_W];
      slen_r     <= in_tdata[SLEN_LSB +: SLEN_W];
      bit_r      <= '0;
      res_hit_r  <= 1'b0;
    end
    if (ctl_i.ld_calc) begin
      r_r <= r_calc;
    end
    if (ctl_i.ld_next) begin
      bit_r <= bit_r + 1'b1;
    end
    // Start each command clean; an allocate on an empty region misses at once
    if (ctl_i.latch) begin
      res_stat_r <= ctl_i.al_miss ? STAT_NO_SPACE : STAT_OK;
    end else if (ctl_i.al_miss) begin
      res_stat_r <= STAT_NO_SPACE;
    end else if (ctl_i.ld_oor) begin
      res_stat_r <= STAT_DROPPED;
    end
    if (ctl_i.al_start) begin
      w_r     <= hint_r[POS_W-1:OFS_W];
      first_r <= 1'b1;
    end
    if (ctl_i.al_step) begin
      w_r     <= w_inc;
      first_r <= 1'b0;
    end
    if (ctl_i.al_hit) begin
      res_hit_r <= 1'b1;
      res_pos_r <= hit_pos;
    end
    if (ctl_i.push) begin
      out_blk_r  <= res_hit_r ? (base_r + BLK_W'(res_pos_r)) : '0;
      out_stat_r <= res_stat_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_blk_r};
  assign out_tuser  = out_stat_r;

  `SBBA_ASSERT_IMPL(a_push_slot, ctl_i.push, out_free, "result pushed into a full output slot")
  `SBBA_ASSERT_IMPL(a_one_writer, 1'b1, $onehot0(map_wr_src), "two map writes in one cycle")
  `SBBA_ASSERT_IMPL(a_ld_in_range, ctl_i.ld_wr, r_ok, "map bit set outside the region")
  `SBBA_ASSERT_IMPL(a_scan_start, ctl_i.al_start, hint_r < size, "scan started past the region")
  `SBBA_ASSERT_NEXT(a_hint_covers, ctl_i.ld_wr, hint_r <= $past(r_pos), "hint above a new bit")

endmodule

`default_nettype wire

// File: hw/rtl/striped_bitmap_block_allocator.sv
// Top level of the striped bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

// Next-fit block allocator over a free bitmap of MAP_BITS bits held in a RAM of
// 64-bit words. Each input word carries one command in in_tuser: clear, load one
// 64-bit word of a stripe bitmap, or allocate one block; every command returns
// exactly one result word. Clear runs a sweep that writes every map word. Load
// walks the 64 stripe bits one by one: a clear or out-of-length bit is skipped,
// a bit outside the region is dropped, and a bit inside is set in the map by a
// read-modify-write of one map word. Allocate reads one map word per cycle from
// the hint word on until it finds a set bit or passes the last region word, and
// misses without a scan when the hint is already past the region.
// The single read port of the map RAM sets the scan pace. After reset the block
// runs the same clearing sweep with in_tready low; configuration writes are
// taken at any time. One command is in work at a time; a finished result sits
// in an output register so the next command is accepted while it waits for
// out_tready.

module striped_bitmap_block_allocator #(
  parameter int unsigned MAP_BITS = sbba_pkg::MAP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [sbba_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [sbba_pkg::CFG_DW-1:0]       cfg_wdata,
  // Command stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // stripe_index[9:0], word_index[13:10], stripe_word[77:14], stripe_len[88:78], zero[95:89]
  input  logic [sbba_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  logic [sbba_pkg::CMD_W-1:0]        in_tuser,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // block_number[63:0], free_count[79:64]
  output logic [sbba_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [sbba_pkg::STAT_W-1:0]       out_tuser
);

  import sbba_pkg::*;

  sbba_ctl_t ctl;
  sbba_sts_t sts;

  sbba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  sbba_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/alloc_check_pkg.sv
// Item types and scoreboard class for the block allocator testbench
`timescale 1ns / 1ps

package alloc_check_pkg;

  import sbba_pkg::*;

  localparam int unsigned MAP_WORDS = MAP_BITS_DEF / WORD_W;
  localparam int unsigned COUNT_TOP = 65535;

  // Command code that the block must ignore apart from echoing the count
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SIDX_W-1:0] stripe_index;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] stripe_word;
    logic [SLEN_W-1:0] stripe_len;
  } alloc_cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0]  block_number;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_count;
  } alloc_result_t;

  // Tracks the allocator state and the results it owes
  class alloc_scoreboard;
    logic [BLK_W-1:0] base_block;
    int unsigned      region_blocks;
    int unsigned      stripe_count;
    int unsigned      search_hint;
    int unsigned      set_count;
    bit [WORD_W-1:0]  free_map [MAP_WORDS];
    alloc_result_t    expected_results [$];

    int unsigned errors;
    int unsigned n_cmds, n_loads, n_drops, n_allocs, n_grants, n_clears;
    bit          saturated;

    function new();
      base_block    = '0;
      region_blocks = REGION_RST;
      stripe_count  = STRIPES_RST;
      clear_map();
    endfunction

    function int unsigned map_size();
      return (region_blocks < MAP_BITS_DEF) ? region_blocks : MAP_BITS_DEF;
    endfunction

    function void clear_map();
      foreach (free_map[i]) free_map[i] = '0;
      search_hint = map_size();
      set_count   = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_BASE:    base_block = value;
        CFG_REGION:  region_blocks = value[SC_W-1:0];
        CFG_STRIPES: stripe_count = value[SC_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted command word and queue the result it owes
    function void note_cmd(alloc_cmd_t c);
      alloc_result_t res;
      int unsigned   size, b, pos, p;
      bit            found;
      size             = map_size();
      res.block_number = '0;
      res.status       = STAT_OK;
      n_cmds++;
      case (c.cmd)
        CMD_CLEAR: begin
          n_clears++;
          clear_map();
        end
        CMD_LOAD: begin
          n_loads++;
          for (int i = 0; i < WORD_W; i++) begin
            b = c.word_index;
            b = b * WORD_W + i;
            if (c.stripe_word[i] && b < c.stripe_len) begin
              pos = c.stripe_index;
              pos = pos + b * stripe_count;
              if (pos >= size) begin
                res.status = STAT_DROPPED;
              end else begin
                free_map[pos / WORD_W][pos % WORD_W] = 1'b1;
                if (pos < search_hint) search_hint = pos;
                if (set_count < COUNT_TOP) set_count++;
                else saturated = 1'b1;
              end
            end
          end
          if (res.status == STAT_DROPPED) n_drops++;
        end
        CMD_ALLOC: begin
          n_allocs++;
          found = 1'b0;
          p     = search_hint;
          while (!found && p < size) begin
            if (free_map[p / WORD_W][p % WORD_W]) found = 1'b1;
            else p++;
          end
          if (found) begin
            n_grants++;
            free_map[p / WORD_W][p % WORD_W] = 1'b0;
            search_hint = p + 1;
            if (set_count > 0) set_count--;
            res.block_number = base_block + BLK_W'(p);
          end else begin
            res.status = STAT_NO_SPACE;
          end
        end
        default: ;
      endcase
      res.free_count = set_count[CNT_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Compare one accepted result word against the oldest expectation
    function void check_result(logic [BLK_W-1:0] blk, logic [STAT_W-1:0] stat,
                               logic [CNT_W-1:0] fc);
      alloc_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result word with no command pending: block %0h status %0d count %0d",
               blk, stat, fc);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (blk !== exp_res.block_number) begin
        $error("block_number: expected %0h, got %0h", exp_res.block_number, blk);
        errors++;
      end
      if (stat !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, stat);
        errors++;
      end
      if (fc !== exp_res.free_count) begin
        $error("free_count: expected %0d, got %0d", exp_res.free_count, fc);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
// Top-level testbench for the striped bitmap block allocator
`timescale 1ns / 1ps

module testbench;

  import sbba_pkg::*;
  import alloc_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_CMDS  = 1800;
  localparam int unsigned SETTLE_TICKS = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_DW-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  alloc_scoreboard sb;
  alloc_cmd_t      seen_cmd;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     sent_cmds     = 0;
  int unsigned     reg_writes    = 0;
  int unsigned     cycle_count   = 0;
  int unsigned     random_goal;

  striped_bitmap_block_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check results first, then note accepted commands
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[63:0], out_tuser, out_tdata[79:64]);
    if (rst_n && in_tvalid && in_tready) begin
      seen_cmd.cmd          = in_tuser;
      seen_cmd.stripe_index = in_tdata[9:0];
      seen_cmd.word_index   = in_tdata[13:10];
      seen_cmd.stripe_word  = in_tdata[77:14];
      seen_cmd.stripe_len   = in_tdata[88:78];
      sb.note_cmd(seen_cmd);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[striped_bitmap_block_allocator] ERROR");
      $finish;
    end
  end

  // Offer one command word, idling first at random, and hold it until taken
  task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [SIDX_W-1:0] sidx,
                          input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] bits,
                          input logic [SLEN_W-1:0] slen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, slen, bits, widx, sidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cmds++;
  endtask

  // Offer a command of the given kind with random payload
  task automatic push_any(input logic [CMD_W-1:0] op);
    push_cmd(op, SIDX_W'($urandom), WIDX_W'($urandom), {$urandom, $urandom},
             SLEN_W'($urandom_range(0, 1024)));
  endtask

  // Hold off new commands until every owed result word has arrived
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    reg_writes++;
  endtask

  // Pick a setting, clear, then mostly stripe loads that fit the region and allocates
  task automatic run_episode(input int unsigned n_ops);
    int unsigned      region, stripes, sidx_top, sidx, run_len, widx, slen, roll;
    logic [BLK_W-1:0] base;
    logic [WORD_W-1:0] bits;
    case ($urandom_range(0, 4))
      0: region = 1024;
      1: region = 1;
      2: region = $urandom_range(1, 128);
      default: region = $urandom_range(1, 1024);
    endcase
    case ($urandom_range(0, 4))
      0: stripes = 1;
      1: stripes = 1024;
      2: stripes = $urandom_range(1, 8);
      3: stripes = $urandom_range(1, 64);
      default: stripes = $urandom_range(1, 1024);
    endcase
    case ($urandom_range(0, 2))
      0: base = '0;
      1: begin
        base = '1;
        base = base - $urandom_range(0, 2047);
      end
      default: base = {$urandom, $urandom};
    endcase
    write_reg(CFG_BASE, base);
    write_reg(CFG_REGION, CFG_DW'(region));
    write_reg(CFG_STRIPES, CFG_DW'(stripes));
    push_any(CMD_CLEAR);
    repeat (n_ops) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_any(CMD_W'($urandom_range(0, 3)));
      end else if (roll < 11) begin
        push_any(CMD_CLEAR);
      end else if (roll < 45) begin
        sidx_top = ((stripes < region) ? stripes : region) - 1;
        sidx     = $urandom_range(0, sidx_top);
        run_len  = (region - sidx + stripes - 1) / stripes;
        widx     = $urandom_range(0, (run_len - 1) / WORD_W);
        slen     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run_len) : run_len;
        case ($urandom_range(0, 3))
          0: bits = '1;
          1: bits = {$urandom, $urandom};
          2: bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          default: bits = 64'd1 << $urandom_range(0, 63);
        endcase
        push_cmd(CMD_LOAD, SIDX_W'(sidx), WIDX_W'(widx), bits, SLEN_W'(slen));
      end else begin
        push_any(CMD_ALLOC);
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_BASE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_CLEAR;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, repeats, drops, zero length, unused code, clear
    push_any(CMD_ALLOC);
    push_cmd(CMD_LOAD, 10'd0, 4'd0, '1, 11'd1024);
    push_cmd(CMD_LOAD, 10'd0, 4'd0, '1, 11'd1024);
    push_cmd(CMD_LOAD, 10'd1023, 4'd15, '1, 11'd1024);
    push_cmd(CMD_LOAD, 10'd0, 4'd15, 64'h8000_0000_0000_0000, 11'd1024);
    push_cmd(CMD_LOAD, 10'd0, 4'd1, '1, 11'd0);
    push_cmd(CMD_LOAD, 10'd5, 4'd0, '1, 11'd3);
    push_any(CMD_ALLOC);
    push_any(CMD_ALLOC);
    push_any(CMD_UNUSED);
    push_any(CMD_CLEAR);
    push_any(CMD_ALLOC);

    // Directed: block number wraps past the top of the 64-bit range
    write_reg(CFG_BASE, '1);
    push_cmd(CMD_LOAD, 10'd3, 4'd0, 64'h3, 11'd64);
    push_any(CMD_ALLOC);
    push_any(CMD_ALLOC);

    // Directed: zero stripes fold every bit onto the stripe index
    write_reg(CFG_STRIPES, 0);
    push_cmd(CMD_LOAD, 10'd9, 4'd2, 64'hF0, 11'd1024);
    push_any(CMD_ALLOC);

    // Directed: a stripe spacing of 1024, then an empty region
    write_reg(CFG_STRIPES, 1024);
    write_reg(CFG_BASE, 0);
    push_cmd(CMD_LOAD, 10'd2, 4'd0, 64'h3, 11'd1024);
    write_reg(CFG_REGION, 0);
    push_any(CMD_ALLOC);
    push_cmd(CMD_LOAD, 10'd0, 4'd0, '1, 11'd1024);

    // Directed: hint left beyond a shrunken region, then a one-block region
    write_reg(CFG_REGION, 1024);
    write_reg(CFG_STRIPES, 1);
    push_any(CMD_CLEAR);
    push_cmd(CMD_LOAD, 10'd0, 4'd15, 64'h100_0000_0000, 11'd1024);
    write_reg(CFG_REGION, 500);
    push_any(CMD_ALLOC);
    write_reg(CFG_REGION, 1);
    push_any(CMD_CLEAR);
    push_cmd(CMD_LOAD, 10'd0, 4'd0, '1, 11'd1024);
    push_any(CMD_ALLOC);

    random_goal = sent_cmds + RANDOM_CMDS;

    // Slow sender, slow receiver, then the reverse
    send_idle_pct = 38;
    recv_idle_pct = 84;
    while (sent_cmds < random_goal - 1450) run_episode($urandom_range(20, 90));
    send_idle_pct = 84;
    recv_idle_pct = 38;
    while (sent_cmds < random_goal - 1100) run_episode($urandom_range(20, 90));

    // Full speed: drive the free count into saturation with full-word loads
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_BASE, {$urandom, $urandom});
    write_reg(CFG_REGION, 1024);
    write_reg(CFG_STRIPES, 1);
    push_any(CMD_CLEAR);
    repeat (1040) push_cmd(CMD_LOAD, 10'd0, WIDX_W'($urandom), '1, 11'd1024);
    repeat (20) push_any(CMD_ALLOC);
    while (sent_cmds < random_goal) run_episode($urandom_range(20, 90));

    // Drain, then watch for stray result words
    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Ran %0d commands over %0d register writes: %0d clears, %0d loads (%0d dropping bits),",
             sb.n_cmds, reg_writes, sb.n_clears, sb.n_loads, sb.n_drops);
    $display("%0d allocates with %0d granted; free count saturation %0s.",
             sb.n_allocs, sb.n_grants, sb.saturated ? "reached" : "not reached");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[striped_bitmap_block_allocator] OK");
    end else begin
      $display("[striped_bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
